// ===== design/wpf_pkg.sv =====
// wpf_pkg: shared types, constants and register codes of the waypoint path follower
// used by every file of the block except wpf_ram; depends on nothing
package wpf_pkg;

  // field widths
  localparam int POS_W   = 24;
  localparam int GAIN_W  = 16;
  localparam int DIFF_W  = POS_W + 1;
  localparam int SQ_W    = 2 * POS_W;
  localparam int PROD_W  = DIFF_W + GAIN_W + 1;
  localparam int SUM_W   = SQ_W + 2;
  localparam int FRAC_W  = 16;
  localparam int AXES    = 3;

  // default store depth
  localparam int PATH_DEPTH_DEF = 1024;

  // configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_ACCURACY = 2'd0,
    REG_PRINT_GAIN = 2'd1,
    REG_TRAVEL_GAIN = 2'd2
  } reg_idx_t;

  localparam logic [GAIN_W-1:0] ACCURACY_RST    = 16'd4000;
  localparam logic [GAIN_W-1:0] PRINT_GAIN_RST  = 16'd1311;
  localparam logic [GAIN_W-1:0] TRAVEL_GAIN_RST = 16'd3277;

  // item kind codes
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // one stored waypoint
  typedef struct packed {
    logic             print;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
  } way_t;

  // what one axis lane hands to the merge stage
  typedef struct packed {
    logic [SQ_W-1:0]  sq;
    logic [POS_W-1:0] vel;
  } lane_res_t;

  // merge stage decision back to the control logic
  typedef struct packed {
    logic fire;
    logic advance;
  } dec_t;

endpackage

// ===== design/wpf_if.sv =====
// wpf_if: valid/ready channel interfaces for input items and result items
// depends on wpf_pkg for field widths
interface wpf_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic signed [wpf_pkg::POS_W-1:0] pos_x;
  logic signed [wpf_pkg::POS_W-1:0] pos_y;
  logic signed [wpf_pkg::POS_W-1:0] pos_z;
  logic                           print_flag;
  logic                           last_point;

  modport source (
    output valid, kind, pos_x, pos_y, pos_z, print_flag, last_point,
    input  ready
  );
  modport sink (
    input  valid, kind, pos_x, pos_y, pos_z, print_flag, last_point,
    output ready
  );
endinterface

interface wpf_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [wpf_pkg::POS_W-1:0] vel_x;
  logic signed [wpf_pkg::POS_W-1:0] vel_y;
  logic signed [wpf_pkg::POS_W-1:0] vel_z;
  logic                           extrude;

  modport source (
    output valid, vel_x, vel_y, vel_z, extrude,
    input  ready
  );
  modport sink (
    input  valid, vel_x, vel_y, vel_z, extrude,
    output ready
  );
endinterface

// ===== design/wpf_ram.sv =====
// wpf_ram: generic single write port, single read port RAM with registered read
// no dependencies
module wpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/wpf_lane.sv =====
// wpf_lane: one axis lane, position error squared, and position error scaled by the selected gain
// depends on wpf_pkg
module wpf_lane (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [wpf_pkg::POS_W-1:0] way,
  input  logic signed [wpf_pkg::POS_W-1:0] pos,
  input  logic [wpf_pkg::GAIN_W-1:0]       gain,
  output wpf_pkg::lane_res_t               res
);

  logic signed [wpf_pkg::DIFF_W-1:0]   diff;
  logic signed [wpf_pkg::GAIN_W:0]     gain_s;
  logic signed [wpf_pkg::SUM_W-1:0]    sq_full;
  logic signed [wpf_pkg::PROD_W-1:0]   prod_next;
  logic [wpf_pkg::SQ_W-1:0]            sq;
  logic signed [wpf_pkg::PROD_W-1:0]   prod;
  logic signed [wpf_pkg::PROD_W-wpf_pkg::FRAC_W-1:0] q;

  // error and the two products
  assign diff      = wpf_pkg::DIFF_W'(way) - wpf_pkg::DIFF_W'(pos);
  assign gain_s    = $signed({1'b0, gain});
  assign sq_full   = diff * diff;
  assign prod_next = diff * gain_s;

  always_ff @(posedge clk) begin
    if (en) begin
      sq   <= sq_full[wpf_pkg::SQ_W-1:0];
      prod <= prod_next;
    end
  end

  // floor shift by the gain fraction, then saturate to the output range
  assign q = prod[wpf_pkg::PROD_W-1:wpf_pkg::FRAC_W];

  always_comb begin
    res.sq = sq;
    if (q[$bits(q)-1:wpf_pkg::POS_W-1] == '0 || q[$bits(q)-1:wpf_pkg::POS_W-1] == '1) begin
      res.vel = q[wpf_pkg::POS_W-1:0];
    end else if (q[$bits(q)-1]) begin
      res.vel = {1'b1, {(wpf_pkg::POS_W-1){1'b0}}};
    end else begin
      res.vel = {1'b0, {(wpf_pkg::POS_W-1){1'b1}}};
    end
  end

endmodule

// ===== design/wpf_merge.sv =====
// wpf_merge: sums the lane squares, compares with the squared radius, holds the result register
// depends on wpf_pkg and wpf_if
module wpf_merge (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  input  wpf_pkg::lane_res_t [wpf_pkg::AXES-1:0]      lanes,
  input  logic                                        ext,
  input  logic [2*wpf_pkg::GAIN_W-1:0]                r2,
  output wpf_pkg::dec_t                               dec,
  wpf_out_if.source                                   result
);

  logic [wpf_pkg::SUM_W-1:0] dist2;
  logic                      reached;
  logic                      out_valid;
  logic                      out_valid_next;

  // squared distance against squared radius
  assign dist2 = wpf_pkg::SUM_W'(lanes[0].sq) + wpf_pkg::SUM_W'(lanes[1].sq)
               + wpf_pkg::SUM_W'(lanes[2].sq);
  assign reached = dist2 < wpf_pkg::SUM_W'(r2);

  // decide when the result register can take a transfer
  assign dec.fire    = in_valid && (!out_valid || result.ready);
  assign dec.advance = dec.fire && reached;

  always_comb begin
    out_valid_next = out_valid && !result.ready;
    if (dec.fire && !reached) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (dec.fire && !reached) begin
      result.vel_x   <= $signed(lanes[0].vel);
      result.vel_y   <= $signed(lanes[1].vel);
      result.vel_z   <= $signed(lanes[2].vel);
      result.extrude <= ext;
    end
  end

  assign result.valid = out_valid;

endmodule

// ===== design/waypoint_path_follower.sv =====
// waypoint_path_follower: loads take effect at their transfer edge; a sample passes the
// s1, lane and result registers and gives no result once it reaches its waypoint or the
// path is used up. Loads transfer every cycle while no sample holds the s1 or s2 stage.
// Synchronous reset (rst high) clears the path state and loads the default radius and gains;
// the waypoint store needs no clearing, so items transfer from the first cycle after reset.
// depends on wpf_pkg, wpf_if, wpf_ram, wpf_lane, wpf_merge
module waypoint_path_follower #(
  parameter int PATH_DEPTH = wpf_pkg::PATH_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  wpf_in_if.sink                       item,
  wpf_out_if.source                    result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wpf_pkg::APB_AW-1:0]   paddr,
  input  logic [wpf_pkg::APB_DW-1:0]   pwdata,
  output logic [wpf_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int CW = $clog2(PATH_DEPTH) + 1;

  // configuration registers
  logic [wpf_pkg::GAIN_W-1:0]   accuracy_um;
  logic [wpf_pkg::GAIN_W-1:0]   print_gain;
  logic [wpf_pkg::GAIN_W-1:0]   travel_gain;
  logic [2*wpf_pkg::GAIN_W-1:0] r2;
  logic                         cfg_wr;
  wpf_pkg::reg_idx_t            cfg_idx;

  // path state
  logic [CW-1:0] path_length;
  logic [CW-1:0] target_index;
  logic [CW-1:0] load_pointer;
  logic          path_active;
  logic [CW-1:0] target_inc;
  logic [CW-1:0] load_inc;

  // sample pipeline
  logic                               s1_valid;
  logic                               s2_valid;
  logic signed [wpf_pkg::POS_W-1:0]   s1_x;
  logic signed [wpf_pkg::POS_W-1:0]   s1_y;
  logic signed [wpf_pkg::POS_W-1:0]   s1_z;
  logic                               s2_ext;
  logic                               exhausted;
  logic                               s1_go;

  // transfer and store signals
  logic                                   accept;
  logic                                   do_load;
  logic                                   store_pt;
  logic                                   close;
  wpf_pkg::way_t                          wdata;
  wpf_pkg::way_t                          rdata;
  logic [AW-1:0]                          raddr;
  logic [wpf_pkg::GAIN_W-1:0]             gain;
  logic signed [wpf_pkg::POS_W-1:0]       way_ax [wpf_pkg::AXES];
  logic signed [wpf_pkg::POS_W-1:0]       pos_ax [wpf_pkg::AXES];
  wpf_pkg::lane_res_t [wpf_pkg::AXES-1:0] lane_res;
  wpf_pkg::dec_t                          dec;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = wpf_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      accuracy_um <= wpf_pkg::ACCURACY_RST;
      print_gain  <= wpf_pkg::PRINT_GAIN_RST;
      travel_gain <= wpf_pkg::TRAVEL_GAIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        wpf_pkg::REG_ACCURACY:    accuracy_um <= pwdata[wpf_pkg::GAIN_W-1:0];
        wpf_pkg::REG_PRINT_GAIN:  print_gain  <= pwdata[wpf_pkg::GAIN_W-1:0];
        wpf_pkg::REG_TRAVEL_GAIN: travel_gain <= pwdata[wpf_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      wpf_pkg::REG_ACCURACY:    prdata = wpf_pkg::APB_DW'(accuracy_um);
      wpf_pkg::REG_PRINT_GAIN:  prdata = wpf_pkg::APB_DW'(print_gain);
      wpf_pkg::REG_TRAVEL_GAIN: prdata = wpf_pkg::APB_DW'(travel_gain);
      default:                  prdata = '0;
    endcase
  end

  // squared radius, refreshed every cycle
  always_ff @(posedge clk) begin
    r2 <= accuracy_um * accuracy_um;
  end

  // ---------------- input transfer and loads ----------------
  assign item.ready = !s1_valid && (!s2_valid || dec.fire);
  assign accept     = item.valid && item.ready;
  assign do_load    = accept && (item.kind == wpf_pkg::KIND_LOAD) && !path_active;
  assign store_pt   = do_load && (load_pointer < CW'(PATH_DEPTH));
  assign close      = do_load && item.last_point;
  assign load_inc   = load_pointer + CW'(store_pt);
  assign target_inc = target_index + CW'(1);

  assign wdata.print = item.print_flag;
  assign wdata.x     = item.pos_x;
  assign wdata.y     = item.pos_y;
  assign wdata.z     = item.pos_z;

  // read the waypoint at the index that holds after this edge
  assign raddr = dec.advance ? target_inc[AW-1:0] : target_index[AW-1:0];

  wpf_ram #(
    .WIDTH ($bits(wpf_pkg::way_t)),
    .DEPTH (PATH_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_pt),
    .waddr (load_pointer[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // path bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      path_length  <= '0;
      target_index <= '0;
      load_pointer <= '0;
      path_active  <= 1'b0;
    end else begin
      if (close) begin
        path_length  <= load_inc;
        target_index <= '0;
        load_pointer <= '0;
        path_active  <= 1'b1;
      end else begin
        load_pointer <= load_inc;
        if (dec.advance) begin
          target_index <= target_inc;
        end
        if (s1_valid && exhausted) begin
          path_active <= 1'b0;
        end
      end
    end
  end

  // ---------------- sample pipeline ----------------
  assign exhausted = target_index >= path_length;
  assign s1_go     = s1_valid && !exhausted;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (item.kind == wpf_pkg::KIND_SAMPLE);
      priority if (s1_go) begin
        s2_valid <= 1'b1;
      end else if (dec.fire) begin
        s2_valid <= 1'b0;
      end
    end
  end

  // sample position and waypoint flag
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x <= item.pos_x;
      s1_y <= item.pos_y;
      s1_z <= item.pos_z;
    end
    if (s1_go) begin
      s2_ext <= rdata.print;
    end
  end

  // axis lanes
  assign gain      = rdata.print ? print_gain : travel_gain;
  assign way_ax[0] = $signed(rdata.x);
  assign way_ax[1] = $signed(rdata.y);
  assign way_ax[2] = $signed(rdata.z);
  assign pos_ax[0] = s1_x;
  assign pos_ax[1] = s1_y;
  assign pos_ax[2] = s1_z;

  for (genvar a = 0; a < wpf_pkg::AXES; a++) begin : g_lane
    wpf_lane u_lane (
      .clk  (clk),
      .en   (s1_go),
      .way  (way_ax[a]),
      .pos  (pos_ax[a]),
      .gain (gain),
      .res  (lane_res[a])
    );
  end

  // distance decision and result register
  wpf_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .lanes    (lane_res),
    .ext      (s2_ext),
    .r2       (r2),
    .dec      (dec),
    .result   (result)
  );

endmodule
